### src/f2fx_pkg.sv
// Package for the float to fixed-point converter.
// Holds the shared widths, register indexes and the configuration struct.
package f2fx_pkg;

    localparam int MAX_WIDTH = 32;
    localparam int FX_W      = 32;
    localparam int FLT_W     = 32;
    localparam int CFG_W     = 6;
    localparam int IDX_W     = 2;
    localparam int K_W       = 10;

    typedef enum logic [IDX_W-1:0] {
        REG_SIGNED_MODE  = 2'd0,
        REG_INTEGER_BITS = 2'd1,
        REG_WIDTH_BITS   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic             signed_mode;
        logic [CFG_W-1:0] integer_bits;
        logic [CFG_W-1:0] width_bits;
    } t_cfg;

endpackage

### src/f2fx_core.sv
// Combinational conversion of one single-precision value to fixed point.
// Depends on f2fx_pkg for widths and the configuration struct.
module f2fx_core
    import f2fx_pkg::*;
(
    input  t_cfg             i_cfg,
    input  logic [FLT_W-1:0] i_value_bits,
    output logic [FX_W-1:0]  o_fixed_value,
    output logic             o_overflow
);

    logic             neg;
    logic [7:0]       e8;
    logic [23:0]      man;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] magbits;
    logic signed [K_W-1:0] frac;
    logic signed [K_W-1:0] k;
    logic [56:0]      mag;
    logic [4:0]       rsh;
    logic [24:0]      rmag;
    logic             ovf;
    logic [FX_W-1:0]  val;
    logic [FX_W-1:0]  mask;

    always_comb begin
        neg = i_value_bits[31];
        e8  = i_value_bits[30:23];
        man = {(e8 != 8'd0), i_value_bits[22:0]};

        if (i_cfg.width_bits == '0) begin
            w = CFG_W'(1);
        end else if (i_cfg.width_bits > CFG_W'(MAX_WIDTH)) begin
            w = CFG_W'(MAX_WIDTH);
        end else begin
            w = i_cfg.width_bits;
        end
        magbits = w - CFG_W'(i_cfg.signed_mode);
        frac    = $signed(K_W'(w)) - $signed(K_W'(i_cfg.integer_bits))
                  - $signed(K_W'(i_cfg.signed_mode));
        k = $signed(K_W'((e8 == 8'd0) ? 8'd1 : e8)) - $signed(K_W'(150)) + frac;

        rsh  = '0;
        rmag = '0;
        ovf  = 1'b0;
        if (k >= 0) begin
            if (k > $signed(K_W'(32))) begin
                mag = '0;
                ovf = (man != '0);
            end else begin
                mag = {33'd0, man} << k[5:0];
            end
        end else begin
            if (-k > $signed(K_W'(25))) begin
                mag = '0;
            end else begin
                rsh  = 5'(-k);
                rmag = 25'(man >> rsh) + 25'((man >> (rsh - 5'd1)) & 24'd1);
                mag  = {32'd0, rmag};
            end
        end
        if ((mag >> magbits) != '0) ovf = 1'b1;
        if (e8 == 8'hFF || magbits == '0) ovf = 1'b1;

        val = mag[FX_W-1:0];
        if (i_cfg.signed_mode && neg) val = (~val) + FX_W'(1);
        mask = {FX_W{1'b1}} >> (CFG_W'(FX_W) - w);

        o_overflow    = ovf;
        o_fixed_value = ovf ? '0 : (val & mask);
    end

endmodule

### src/float_to_fixed_converter_top.sv
// Top level of the float to fixed-point converter: channels, config, pipeline.
// Depends on f2fx_pkg and f2fx_core.
//
// Usage:
//   Input stream (i_s_*): tdata carries one IEEE-754 single value per transfer.
//   Output stream (o_m_*): tdata carries the fixed-point result in its low
//   width bits; tuser is the overflow flag (then tdata is zero).
//   Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index (0 signed_mode,
//   1 integer_bits, 2 width_bits) and i_cfg_data; write only while idle.
// Path: an input transfer passes the input register, the conversion logic
// and the result register before the result is valid.
// Throughput: one item per cycle while tready is high; the conversion is a
// single pass of shift, round and negate between the two registers.
// Reset (synchronous, active low): both stages empty, registers back to
// signed_mode 1, integer_bits 7, width_bits 16.
// Stall: when the receiver holds tready low the result stays put, the input
// register keeps one more item and tready on the input side drops.
module float_to_fixed_converter_top
    import f2fx_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [FLT_W-1:0] i_s_tdata,   // [31:0] value_bits
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [FX_W-1:0]  o_m_tdata,   // [31:0] fixed_value
    output logic             o_m_tuser,   // [0] overflow
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cfg             r_cfg;
    logic             r_v1;
    logic [FLT_W-1:0] r_in;
    logic             r_v2;
    logic [FX_W-1:0]  r_out;
    logic             r_ovf;
    logic             adv2;
    logic [FX_W-1:0]  conv_val;
    logic             conv_ovf;

    assign o_cfg_ready = 1'b1;
    assign adv2        = !r_v2 || i_m_tready;
    assign o_s_tready  = !r_v1 || adv2;
    assign o_m_tvalid  = r_v2;
    assign o_m_tdata   = r_out;
    assign o_m_tuser   = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.signed_mode  <= 1'b1;
            r_cfg.integer_bits <= CFG_W'(7);
            r_cfg.width_bits   <= CFG_W'(16);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SIGNED_MODE:  r_cfg.signed_mode  <= i_cfg_data[0];
                REG_INTEGER_BITS: r_cfg.integer_bits <= i_cfg_data;
                REG_WIDTH_BITS:   r_cfg.width_bits   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_s_tready) r_v1 <= i_s_tvalid;
            if (adv2)       r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) r_in <= i_s_tdata;
        if (adv2) begin
            r_out <= conv_val;
            r_ovf <= conv_ovf;
        end
    end

    f2fx_core u_core (
        .i_cfg         (r_cfg),
        .i_value_bits  (r_in),
        .o_fixed_value (conv_val),
        .o_overflow    (conv_ovf)
    );

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_ovf) |-> (r_out == '0))
        else $error("overflow result with nonzero data");

    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !adv2) |=> (r_v1 && $stable(r_in)))
        else $error("input stage lost an item under stall");

    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && adv2) |=> r_v2)
        else $error("item not moved to result stage");

endmodule
